### rtl/core/pgrr_pkg.sv
// pgrr_pkg: shared types and constants for the packet gap resend requester
// holds header type codes, result kind codes, register indexes and the
// descriptor passed from the front end to the back end; no dependencies
package pgrr_pkg;

   // header type byte codes
   localparam logic [7:0] T_DATA   = 8'h33;
   localparam logic [7:0] T_RESENT = 8'h34;
   localparam logic [7:0] T_OTHER  = 8'h35;
   localparam logic [7:0] T_START  = 8'h30;
   localparam logic [7:0] T_END    = 8'h3f;

   // result kinds
   localparam logic [2:0] K_FORWARD = 3'd0;
   localparam logic [2:0] K_BADTYPE = 3'd1;
   localparam logic [2:0] K_FIRST   = 3'd2;
   localparam logic [2:0] K_TOOBIG  = 3'd3;
   localparam logic [2:0] K_RESEND  = 3'd4;

   // configuration register indexes and reset values
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_PACKETS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RESEND    = 2'd1;
   localparam logic [15:0] TOTAL_PACKETS_RESET = 16'd152;
   localparam logic [15:0] MAX_RESEND_RESET    = 16'd100;

   // work for one request: optional tail resend, optional head or gap resend, final kind
   typedef struct packed {
      logic        tail_en;
      logic [23:0] tail_stamp;
      logic [15:0] tail_start;
      logic [15:0] tail_count;
      logic        head_en;
      logic [7:0]  head_camera;
      logic [23:0] head_stamp;
      logic [15:0] head_start;
      logic [15:0] head_count;
      logic [2:0]  final_kind;
   } desc_type;

   // status of the descriptor queue as seen by the two ends
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

### rtl/core/pgrr_front.sv
// pgrr_front: classifies each header, keeps the frame tracking state and config
// registers, and builds one descriptor per accepted request
// depends on pgrr_pkg
module pgrr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [7:0]                           packet_type,
   input  logic [7:0]                           camera_byte,
   input  logic [23:0]                          frame_stamp,
   input  logic [15:0]                          packet_number,
   input  logic                                 csr_wr_en,
   input  logic [pgrr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                          csr_wdata,
   output pgrr_pkg::desc_type                   desc
);

   logic        started_ff, started_in;
   logic [15:0] cur_packet_ff, cur_packet_in;
   logic [23:0] cur_stamp_ff, cur_stamp_in;
   logic [15:0] prev_packet_ff, prev_packet_in;
   logic [23:0] prev_stamp_ff, prev_stamp_in;
   logic [15:0] total_packets_ff, total_packets_in;
   logic [15:0] max_resend_ff, max_resend_in;

   logic               type_known;
   logic               is_data;
   logic               is_start;
   logic [15:0]        cur_pkt_eff;
   logic [23:0]        cur_stamp_eff;
   logic [15:0]        prev_inc;
   logic signed [17:0] tail_lost;
   logic signed [17:0] head_lost;
   logic signed [17:0] gap_lost;
   logic               forward;

   function automatic logic too_big(input logic signed [17:0] lost,
                                    input logic [15:0] limit);
      too_big = (lost > 18'sd0) && (lost > $signed({2'b00, limit}));
   endfunction

   always_comb begin
      type_known = packet_type inside {pgrr_pkg::T_DATA, pgrr_pkg::T_RESENT,
                                       pgrr_pkg::T_OTHER, pgrr_pkg::T_START,
                                       pgrr_pkg::T_END};
      is_data  = (packet_type == pgrr_pkg::T_DATA);
      is_start = (packet_type == pgrr_pkg::T_START);
      // only data headers latch a new current position
      cur_pkt_eff   = is_data ? packet_number : cur_packet_ff;
      cur_stamp_eff = is_data ? frame_stamp : cur_stamp_ff;
      prev_inc      = prev_packet_ff + 16'd1;
      tail_lost = $signed({2'b00, total_packets_ff}) - $signed({2'b00, prev_packet_ff})
                  - 18'sd1;
      head_lost = $signed({2'b00, cur_pkt_eff}) - 18'sd1;
      gap_lost  = $signed({2'b00, cur_pkt_eff}) - $signed({2'b00, prev_packet_ff})
                  - 18'sd1;
   end

   always_comb begin
      desc            = '0;
      desc.final_kind = pgrr_pkg::K_FORWARD;
      forward         = 1'b0;
      started_in      = started_ff;
      cur_packet_in   = cur_packet_ff;
      cur_stamp_in    = cur_stamp_ff;
      prev_packet_in  = prev_packet_ff;
      prev_stamp_in   = prev_stamp_ff;

      if (!type_known) begin
         desc.final_kind = pgrr_pkg::K_BADTYPE;
      end else begin
         cur_packet_in = cur_pkt_eff;
         cur_stamp_in  = cur_stamp_eff;
         if (!started_ff) begin
            started_in      = 1'b1;
            prev_packet_in  = cur_pkt_eff;
            prev_stamp_in   = cur_stamp_eff;
            desc.final_kind = pgrr_pkg::K_FIRST;
         end else if ((cur_stamp_eff != prev_stamp_ff) && (is_data || is_start)) begin
            // frame change: tail of the old frame, then head of the new one
            if (too_big(tail_lost, max_resend_ff)) begin
               desc.final_kind = pgrr_pkg::K_TOOBIG;
            end else begin
               if (tail_lost > 18'sd0) begin
                  desc.tail_en    = 1'b1;
                  desc.tail_stamp = prev_stamp_ff;
                  desc.tail_start = prev_inc;
                  desc.tail_count = tail_lost[15:0];
               end
               if (too_big(head_lost, max_resend_ff)) begin
                  desc.final_kind = pgrr_pkg::K_TOOBIG;
                  if (tail_lost > 18'sd0) begin
                     prev_packet_in = prev_inc;
                  end
               end else begin
                  if (head_lost > 18'sd0) begin
                     desc.head_en     = 1'b1;
                     desc.head_camera = camera_byte;
                     desc.head_stamp  = frame_stamp;
                     desc.head_start  = 16'd1;
                     desc.head_count  = head_lost[15:0];
                  end
                  forward = 1'b1;
               end
            end
         end else if (is_data && (cur_pkt_eff != 16'd0)) begin
            // gap inside the frame
            if (too_big(gap_lost, max_resend_ff)) begin
               desc.final_kind = pgrr_pkg::K_TOOBIG;
            end else begin
               if (gap_lost > 18'sd0) begin
                  desc.head_en     = 1'b1;
                  desc.head_camera = camera_byte;
                  desc.head_stamp  = frame_stamp;
                  desc.head_start  = prev_inc;
                  desc.head_count  = gap_lost[15:0];
               end
               forward = 1'b1;
            end
         end else begin
            forward = 1'b1;
         end
         if (forward) begin
            prev_packet_in = cur_pkt_eff;
            prev_stamp_in  = cur_stamp_eff;
         end
      end
   end

   always_comb begin
      total_packets_in = total_packets_ff;
      max_resend_in    = max_resend_ff;
      if (csr_wr_en) begin
         if (csr_index == pgrr_pkg::CSR_TOTAL_PACKETS) begin
            total_packets_in = csr_wdata;
         end
         if (csr_index == pgrr_pkg::CSR_MAX_RESEND) begin
            max_resend_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff       <= 1'b0;
         cur_packet_ff    <= '0;
         cur_stamp_ff     <= '0;
         prev_packet_ff   <= '0;
         prev_stamp_ff    <= '0;
         total_packets_ff <= pgrr_pkg::TOTAL_PACKETS_RESET;
         max_resend_ff    <= pgrr_pkg::MAX_RESEND_RESET;
      end else begin
         total_packets_ff <= total_packets_in;
         max_resend_ff    <= max_resend_in;
         if (accept) begin
            started_ff     <= started_in;
            cur_packet_ff  <= cur_packet_in;
            cur_stamp_ff   <= cur_stamp_in;
            prev_packet_ff <= prev_packet_in;
            prev_stamp_ff  <= prev_stamp_in;
         end
      end
   end

endmodule

### rtl/core/pgrr_desc_fifo.sv
// pgrr_desc_fifo: short register queue of descriptors between front and back end
// depends on pgrr_pkg
module pgrr_desc_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pgrr_pkg::desc_type      push_desc,
   input  logic                    pop,
   output pgrr_pkg::desc_type      head_desc,
   output pgrr_pkg::fifo_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pgrr_pkg::desc_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      stat.full  = (count_ff == CNT_W'(DEPTH));
      stat.empty = (count_ff == '0);
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      head_desc  = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### rtl/core/pgrr_back.sv
// pgrr_back: expands each descriptor into its resend results and final result
// and holds them in the output register; depends on pgrr_pkg
module pgrr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pgrr_pkg::desc_type      head_desc,
   input  pgrr_pkg::fifo_stat_type fifo_stat,
   output logic                    fifo_pop,
   input  logic                    pop,
   output logic                    empty,
   output logic [2:0]              rsp_kind,
   output logic [7:0]              rsp_req_camera,
   output logic [23:0]             rsp_req_stamp,
   output logic [15:0]             rsp_req_start,
   output logic [15:0]             rsp_req_count,
   output logic                    rsp_last_of_run
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  camera_ff, camera_in;
   logic [23:0] stamp_ff, stamp_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] count_ff, count_in;
   logic        last_ff, last_in;
   logic        tail_done_ff, tail_done_in;
   logic        head_done_ff, head_done_in;
   logic        load;
   logic        sel_tail;
   logic        sel_head;

   always_comb begin
      load     = !rsp_valid_ff || pop;
      sel_tail = head_desc.tail_en && !tail_done_ff;
      sel_head = !sel_tail && head_desc.head_en && !head_done_ff;
      fifo_pop = load && !fifo_stat.empty && !sel_tail && !sel_head;

      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      camera_in    = camera_ff;
      stamp_in     = stamp_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      tail_done_in = tail_done_ff;
      head_done_in = head_done_ff;

      if (load) begin
         rsp_valid_in = !fifo_stat.empty;
         kind_in      = pgrr_pkg::K_RESEND;
         camera_in    = '0;
         stamp_in     = '0;
         start_in     = '0;
         count_in     = '0;
         last_in      = 1'b0;
         if (!fifo_stat.empty) begin
            if (sel_tail) begin
               stamp_in     = head_desc.tail_stamp;
               start_in     = head_desc.tail_start;
               count_in     = head_desc.tail_count;
               tail_done_in = 1'b1;
            end else if (sel_head) begin
               camera_in    = head_desc.head_camera;
               stamp_in     = head_desc.head_stamp;
               start_in     = head_desc.head_start;
               count_in     = head_desc.head_count;
               head_done_in = 1'b1;
            end else begin
               kind_in      = head_desc.final_kind;
               last_in      = 1'b1;
               tail_done_in = 1'b0;
               head_done_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tail_done_ff <= 1'b0;
         head_done_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tail_done_ff <= tail_done_in;
         head_done_ff <= head_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      camera_ff <= camera_in;
      stamp_ff  <= stamp_in;
      start_ff  <= start_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
   end

   assign empty           = !rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_req_camera  = camera_ff;
   assign rsp_req_stamp   = stamp_ff;
   assign rsp_req_start   = start_ff;
   assign rsp_req_count   = count_ff;
   assign rsp_last_of_run = last_ff;

`ifndef NO_ASSERTIONS
   // a non-resend result is always the last of its run and carries no request
   a_final_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff != pgrr_pkg::K_RESEND) |->
         last_ff && (count_ff == 16'd0) && (start_ff == 16'd0))
      else $error("final result carries request fields");

   // a resend result never closes a run and always asks for at least one packet
   a_resend_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (kind_ff == pgrr_pkg::K_RESEND) |->
         !last_ff && (count_ff != 16'd0))
      else $error("malformed resend result");

   // partial progress on a descriptor only exists while it is still queued
   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      (tail_done_ff || head_done_ff) |-> !fifo_stat.empty)
      else $error("resend progress without pending descriptor");
`endif

endmodule

### rtl/core/packet_gap_resend_requester_core.sv
// packet_gap_resend_requester_core: accepted requests are queued as descriptors
// and expanded into results on the rsp ports; one request can be taken every
// cycle while the descriptor queue has room; the back end gives 1 to 3 results
// per request, one per cycle while popped, through its single output register
// reset is synchronous and active high: queue and output empty, frame state
// zero, total_packets back to 152 and max_resend back to 100
module packet_gap_resend_requester_core #(
   parameter int DESC_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [7:0]                       req_packet_type,
   input  logic [7:0]                       req_camera_byte,
   input  logic [23:0]                      req_frame_stamp,
   input  logic [15:0]                      req_packet_number,
   output logic                             empty,
   input  logic                             pop,
   output logic [2:0]                       rsp_kind,
   output logic [7:0]                       rsp_req_camera,
   output logic [23:0]                      rsp_req_stamp,
   output logic [15:0]                      rsp_req_start,
   output logic [15:0]                      rsp_req_count,
   output logic                             rsp_last_of_run,
   input  logic                             csr_wr_en,
   input  logic [pgrr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_wdata
);

   pgrr_pkg::desc_type      new_desc;
   pgrr_pkg::desc_type      head_desc;
   pgrr_pkg::fifo_stat_type fifo_stat;
   logic                    accept;
   logic                    fifo_pop;

   assign full   = fifo_stat.full;
   assign accept = push && !fifo_stat.full;

   pgrr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .packet_type   (req_packet_type),
      .camera_byte   (req_camera_byte),
      .frame_stamp   (req_frame_stamp),
      .packet_number (req_packet_number),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .desc          (new_desc)
   );

   pgrr_desc_fifo #(
      .DEPTH (DESC_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_desc (new_desc),
      .pop       (fifo_pop),
      .head_desc (head_desc),
      .stat      (fifo_stat)
   );

   pgrr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_desc       (head_desc),
      .fifo_stat       (fifo_stat),
      .fifo_pop        (fifo_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_kind        (rsp_kind),
      .rsp_req_camera  (rsp_req_camera),
      .rsp_req_stamp   (rsp_req_stamp),
      .rsp_req_start   (rsp_req_start),
      .rsp_req_count   (rsp_req_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

### bench/packet_gap_resend_requester_core_test.sv
// packet_gap_resend_requester_core_test: self-checking bench for the resend requester core
// drives header requests, predicts resend/verdict results and checks them in order
// depends on pgrr_pkg and packet_gap_resend_requester_core
`timescale 1ns / 1ps

module packet_gap_resend_requester_core_test;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0]  ptype;
      logic [7:0]  camera;
      logic [23:0] stamp;
      logic [15:0] pnum;
   } header_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  camera;
      logic [23:0] stamp;
      logic [15:0] start;
      logic [15:0] count;
      logic        last;
   } verdict_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             push = 1'b0;
   logic                             full;
   logic [7:0]                       req_packet_type = '0;
   logic [7:0]                       req_camera_byte = '0;
   logic [23:0]                      req_frame_stamp = '0;
   logic [15:0]                      req_packet_number = '0;
   logic                             empty;
   logic                             pop = 1'b0;
   logic [2:0]                       rsp_kind;
   logic [7:0]                       rsp_req_camera;
   logic [23:0]                      rsp_req_stamp;
   logic [15:0]                      rsp_req_start;
   logic [15:0]                      rsp_req_count;
   logic                             rsp_last_of_run;
   logic                             csr_wr_en = 1'b0;
   logic [pgrr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]                      csr_wdata = '0;

   packet_gap_resend_requester_core DUT (.*);

   always #2 clock = ~clock;

   header_type  header_queue[$];
   verdict_type awaited_verdicts[$];
   int          fail_count = 0;
   int          idle_odds = 0;   // 0 means no idling on either side
   int          cycle_count = 0;

   // shadow of the block's registers and frame tracking
   int          frame_len = pgrr_pkg::TOTAL_PACKETS_RESET;
   int          gap_limit = pgrr_pkg::MAX_RESEND_RESET;
   bit          seen_first = 1'b0;
   logic [15:0] cur_pnum = '0;
   logic [23:0] cur_stamp = '0;
   logic [15:0] last_pnum = '0;
   logic [23:0] last_stamp = '0;

   // stream generator state
   int          gen_pnum = 0;
   logic [23:0] gen_stamp = '0;
   logic [7:0]  gen_camera = '0;

   function automatic void expect_verdict(logic [2:0] kind, logic [7:0] camera,
                                          logic [23:0] stamp, logic [15:0] start,
                                          logic [15:0] count, logic last);
      verdict_type v;
      v.kind = kind;
      v.camera = camera;
      v.stamp = stamp;
      v.start = start;
      v.count = count;
      v.last = last;
      awaited_verdicts = {awaited_verdicts, v};
   endfunction

   function automatic void judge_header(header_type h);
      int lost;
      if (!(h.ptype inside {pgrr_pkg::T_DATA, pgrr_pkg::T_RESENT, pgrr_pkg::T_OTHER,
                            pgrr_pkg::T_START, pgrr_pkg::T_END})) begin
         expect_verdict(pgrr_pkg::K_BADTYPE, '0, '0, '0, '0, 1'b1);
         return;
      end
      if (h.ptype == pgrr_pkg::T_DATA) begin
         cur_stamp = h.stamp;
         cur_pnum = h.pnum;
      end
      if (!seen_first) begin
         seen_first = 1'b1;
         last_pnum = cur_pnum;
         last_stamp = cur_stamp;
         expect_verdict(pgrr_pkg::K_FIRST, '0, '0, '0, '0, 1'b1);
         return;
      end
      if (cur_stamp != last_stamp &&
          (h.ptype == pgrr_pkg::T_DATA || h.ptype == pgrr_pkg::T_START)) begin
         // missing tail of the old frame, then missing head of the new one
         lost = frame_len - int'(last_pnum) - 1;
         if (lost > 0 && lost > gap_limit) begin
            expect_verdict(pgrr_pkg::K_TOOBIG, '0, '0, '0, '0, 1'b1);
            return;
         end
         if (lost > 0) begin
            last_pnum = last_pnum + 16'd1;
            expect_verdict(pgrr_pkg::K_RESEND, '0, last_stamp, last_pnum, lost[15:0], 1'b0);
         end
         lost = int'(cur_pnum) - 1;
         if (lost > 0 && lost > gap_limit) begin
            expect_verdict(pgrr_pkg::K_TOOBIG, '0, '0, '0, '0, 1'b1);
            return;
         end
         if (lost > 0)
            expect_verdict(pgrr_pkg::K_RESEND, h.camera, h.stamp, 16'd1, lost[15:0], 1'b0);
      end else if (h.ptype == pgrr_pkg::T_DATA && cur_pnum != 0) begin
         lost = int'(cur_pnum) - int'(last_pnum) - 1;
         if (lost > 0 && lost > gap_limit) begin
            expect_verdict(pgrr_pkg::K_TOOBIG, '0, '0, '0, '0, 1'b1);
            return;
         end
         if (lost > 0)
            expect_verdict(pgrr_pkg::K_RESEND, h.camera, h.stamp, last_pnum + 16'd1,
                           lost[15:0], 1'b0);
      end
      last_pnum = cur_pnum;
      last_stamp = cur_stamp;
      expect_verdict(pgrr_pkg::K_FORWARD, '0, '0, '0, '0, 1'b1);
   endfunction

   // request driver
   int gap_left = 0;
   always @(posedge clock) begin
      header_type h;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            h.ptype = req_packet_type;
            h.camera = req_camera_byte;
            h.stamp = req_frame_stamp;
            h.pnum = req_packet_number;
            judge_header(h);
         end
         if (push && full) begin
            // hold the offered request
         end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (header_queue.size() > 0) begin
            h = header_queue.pop_front();
            req_packet_type <= h.ptype;
            req_camera_byte <= h.camera;
            req_frame_stamp <= h.stamp;
            req_packet_number <= h.pnum;
            push <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               gap_left = $urandom_range(1, 6);
         end else begin
            push <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // result monitor
   int checked = 0;
   int hold_left = 0;
   int pause_left = 0;
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (awaited_verdicts.size() == 0) begin
               $error("result with no request outstanding: kind %0d", rsp_kind);
               fail_count++;
            end else begin
               want = awaited_verdicts.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("req_camera", want.camera, rsp_req_camera);
               check_field("req_stamp", want.stamp, rsp_req_stamp);
               check_field("req_start", want.start, rsp_req_start);
               check_field("req_count", want.count, rsp_req_count);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
            checked++;
            // long back-pressure so the descriptor queue fills and full rises
            if (checked == 30 || checked == 150)
               hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (pause_left > 0) begin
            pause_left--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
               pause_left = $urandom_range(1, 6);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic add_header(logic [7:0] ptype, logic [7:0] camera, logic [23:0] stamp,
                             logic [15:0] pnum);
      header_type h;
      h.ptype = ptype;
      h.camera = camera;
      h.stamp = stamp;
      h.pnum = pnum;
      header_queue = {header_queue, h};
   endtask

   task automatic write_reg(logic [pgrr_pkg::CSR_INDEX_W-1:0] index, logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         pgrr_pkg::CSR_TOTAL_PACKETS: frame_len = value;
         pgrr_pkg::CSR_MAX_RESEND:    gap_limit = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (header_queue.size() != 0 || push || awaited_verdicts.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   // mostly well-formed frame streams, some other types, bad types and noise
   task automatic queue_headers(int count);
      int          i;
      int          roll;
      logic [7:0]  ptype;
      for (i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            if (gen_pnum + 1 >= frame_len || $urandom_range(0, 15) == 0) begin
               gen_stamp = gen_stamp + 24'd1;
               gen_camera = 8'($urandom_range(0, 255));
               gen_pnum = $urandom_range(0, 2);
               ptype = ($urandom_range(0, 3) == 0) ? pgrr_pkg::T_START : pgrr_pkg::T_DATA;
            end else begin
               if ($urandom_range(0, 9) == 0)
                  gen_pnum += $urandom_range(2, 200);
               else if ($urandom_range(0, 3) == 0)
                  gen_pnum += $urandom_range(2, 8);
               else
                  gen_pnum += 1;
               gen_pnum &= 16'hffff;
               ptype = pgrr_pkg::T_DATA;
            end
            add_header(ptype, gen_camera, gen_stamp, gen_pnum[15:0]);
         end else if (roll < 78) begin
            case ($urandom_range(0, 3))
               0: ptype = pgrr_pkg::T_RESENT;
               1: ptype = pgrr_pkg::T_OTHER;
               2: ptype = pgrr_pkg::T_END;
               default: ptype = pgrr_pkg::T_START;
            endcase
            add_header(ptype, gen_camera, gen_stamp, 16'($urandom_range(0, gen_pnum)));
         end else if (roll < 88) begin
            add_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       24'($urandom), 16'($urandom));
         end else begin
            case ($urandom_range(0, 2))
               0: ptype = pgrr_pkg::T_DATA;
               1: ptype = pgrr_pkg::T_START;
               default: ptype = 8'($urandom_range(0, 255));
            endcase
            add_header(ptype, 8'($urandom_range(0, 255)), 24'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      gen_stamp = 24'($urandom);
      gen_camera = 8'($urandom_range(0, 255));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: bad types, first header, gaps, frame changes, limits, extremes
      idle_odds = 4;
      add_header(8'h00, 8'h00, 24'h000000, 16'h0000);
      add_header(8'hff, 8'hff, 24'hffffff, 16'hffff);
      add_header(8'h36, 8'h01, 24'h000010, 16'h0001);
      add_header(pgrr_pkg::T_DATA, 8'h01, 24'd10, 16'd5);
      add_header(pgrr_pkg::T_DATA, 8'h01, 24'd10, 16'd6);
      add_header(pgrr_pkg::T_DATA, 8'h01, 24'd10, 16'd9);
      add_header(pgrr_pkg::T_DATA, 8'h01, 24'd10, 16'd9);
      add_header(pgrr_pkg::T_DATA, 8'h01, 24'd10, 16'd0);
      add_header(pgrr_pkg::T_DATA, 8'h01, 24'd10, 16'd150);
      add_header(pgrr_pkg::T_RESENT, 8'h01, 24'd99, 16'd3);
      add_header(pgrr_pkg::T_DATA, 8'h02, 24'd11, 16'd3);
      add_header(pgrr_pkg::T_START, 8'h02, 24'd5, 16'd0);
      add_header(pgrr_pkg::T_OTHER, 8'h02, 24'd11, 16'd3);
      add_header(pgrr_pkg::T_END, 8'h02, 24'd11, 16'd3);
      add_header(pgrr_pkg::T_DATA, 8'h02, 24'd11, 16'd60);
      add_header(pgrr_pkg::T_DATA, 8'h02, 24'd11, 16'd140);
      // tail requested, then head too large
      add_header(pgrr_pkg::T_DATA, 8'h03, 24'd12, 16'd120);
      add_header(pgrr_pkg::T_START, 8'h04, 24'd77, 16'd0);
      add_header(pgrr_pkg::T_DATA, 8'h03, 24'd12, 16'd1);
      // gap exactly at the limit, then one past it
      add_header(pgrr_pkg::T_DATA, 8'h03, 24'd12, 16'd102);
      add_header(pgrr_pkg::T_DATA, 8'h03, 24'd12, 16'd204);
      add_header(pgrr_pkg::T_DATA, 8'hff, 24'hffffff, 16'hffff);
      add_header(pgrr_pkg::T_DATA, 8'h00, 24'h000000, 16'h0000);
      add_header(pgrr_pkg::T_END, 8'h80, 24'h800000, 16'h8000);
      wait_idle();

      write_reg(pgrr_pkg::CSR_TOTAL_PACKETS, 16'd1);
      write_reg(pgrr_pkg::CSR_MAX_RESEND, 16'd0);
      idle_odds = 3;
      queue_headers(25);
      wait_idle();

      write_reg(pgrr_pkg::CSR_TOTAL_PACKETS, 16'hffff);
      write_reg(pgrr_pkg::CSR_MAX_RESEND, 16'hffff);
      idle_odds = 0;
      queue_headers(25);
      wait_idle();

      // zero frame length: tail count goes negative
      write_reg(pgrr_pkg::CSR_TOTAL_PACKETS, 16'd0);
      write_reg(pgrr_pkg::CSR_MAX_RESEND, 16'd3);
      idle_odds = 5;
      queue_headers(15);
      wait_idle();

      write_reg(pgrr_pkg::CSR_TOTAL_PACKETS, pgrr_pkg::TOTAL_PACKETS_RESET);
      write_reg(pgrr_pkg::CSR_MAX_RESEND, pgrr_pkg::MAX_RESEND_RESET);
      idle_odds = 4;
      queue_headers(50);
      wait_idle();

      write_reg(pgrr_pkg::CSR_TOTAL_PACKETS, 16'($urandom_range(2, 20)));
      write_reg(pgrr_pkg::CSR_MAX_RESEND, 16'($urandom_range(0, 10)));
      idle_odds = 2;
      queue_headers(50);
      wait_idle();

      // closing stretch at full rate on both sides
      write_reg(pgrr_pkg::CSR_TOTAL_PACKETS, 16'd24);
      write_reg(pgrr_pkg::CSR_MAX_RESEND, 16'd12);
      idle_odds = 0;
      queue_headers(40);
      wait_idle();

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
